// ===== hdl/clu_pkg.sv =====
// Shared types, constants and command/status structs of the Crout LU solver.
package clu_pkg;

    localparam int MAX_ORDER = 16;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_ORDER);
    localparam int SIZE_W    = 5;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int CNT_W     = IDX_W + 1;

    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_SOLVE  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PIVOT = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // Accumulator target of a dot product.
    typedef enum logic [1:0] {
        DST_MAT_PLAIN = 2'd0,   // M(r,c) = sat(M(r,c) - acc)
        DST_MAT_DIV   = 2'd1,   // M(r,c) = div(sat(M(r,c) - acc), M(i,i))
        DST_X_DIV     = 2'd2,   // x[j] = div(sat(b[j] - acc), M(j,j))
        DST_X_PLAIN   = 2'd3    // x[j] = sat(x[j] - acc)
    } dst_t;

    // One dot-product job: acc = sum over k in [k_lo, k_hi) of
    // A(r,k) * B(k,c), where B is the matrix or the x vector.
    typedef struct packed {
        logic              start;
        dst_t              dst;
        logic [IDX_W-1:0]  r;
        logic [IDX_W-1:0]  c;
        logic [CNT_W-1:0]  k_lo;
        logic [CNT_W-1:0]  k_hi;
        logic              clr_flags;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
    } dp_sts_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] v, output logic f);
        logic [31:0] res;
        f = 1'b0;
        if (v > 64'sh7FFFFFFF) begin
            res = 32'h7FFFFFFF; f = 1'b1;
        end else if (v < -64'sh80000000) begin
            res = 32'h80000000; f = 1'b1;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/clu_div.sv =====
// Iterative signed divider, one quotient bit per cycle, with saturation.
module clu_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [31:0] quo,
    output logic        sat
);
    import clu_pkg::*;

    localparam int DW = 32 + FRAC_BITS;  // dividend width
    localparam int QW = DW;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] rem_dvd_reg, rem_dvd_next;
    logic [32:0]   part_reg, part_next;
    logic [31:0]   dmag_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, done_reg;
    logic [31:0]   quo_reg;
    logic          sat_reg;

    logic [DW-1:0]     nmag;
    logic [32:0]       shifted;
    logic [32:0]       diff;
    logic signed [DW:0] sq;
    logic signed [63:0] sq64;
    logic              f;
    logic [31:0]       qs;

    always_comb begin
        nmag     = num[31] ? DW'(-{{(DW-32){num[31]}}, num} << FRAC_BITS)
                           : DW'({{(DW-32){1'b0}}, num} << FRAC_BITS);
        shifted  = {part_reg[31:0], rem_dvd_reg[DW-1]};
        diff     = shifted - {1'b0, dmag_reg};
        part_next    = diff[32] ? shifted : diff;
        rem_dvd_next = {rem_dvd_reg[DW-2:0], ~diff[32]};
        cnt_next     = cnt_reg - CW'(1);
        sq   = neg_reg ? -$signed({1'b0, rem_dvd_reg}) : $signed({1'b0, rem_dvd_reg});
        sq64 = 64'(sq);
        qs   = sat32(sq64, f);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg    <= 1'b1;
                rem_dvd_reg <= num[31] ? DW'(({{(DW-32){1'b0}}, -num}) << FRAC_BITS)
                                       : nmag;
                part_reg    <= '0;
                dmag_reg    <= den[31] ? -den : den;
                neg_reg     <= num[31] ^ den[31];
                cnt_reg     <= CW'(QW);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    quo_reg  <= qs;
                    sat_reg  <= f;
                end else begin
                    rem_dvd_reg <= rem_dvd_next;
                    part_reg    <= part_next;
                    cnt_reg     <= cnt_next;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign sat  = sat_reg;
endmodule

// ===== hdl/clu_datapath.sv =====
// Datapath: matrix and vector memories, multiply-accumulate, divider, x store.
module clu_datapath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    ld_a,
    input  logic                    ld_b,
    input  logic [clu_pkg::IDX_W-1:0] ld_row,
    input  logic [clu_pkg::IDX_W-1:0] ld_col,
    input  logic [31:0]             ld_value,
    input  clu_pkg::dp_cmd_t        cmd,
    output clu_pkg::dp_sts_t        sts,
    input  logic [clu_pkg::IDX_W-1:0] xrd_idx,
    output logic [31:0]             xrd_data,
    output logic [1:0]              status
);
    import clu_pkg::*;

    typedef enum logic [2:0] {
        D_IDLE, D_RDA, D_MAC, D_WAIT, D_FIN, D_DIVRD, D_DIV, D_DONE
    } dstate_t;

    logic [31:0] mat_mem [MAX_ORDER*MAX_ORDER];
    logic [31:0] vec_mem [MAX_ORDER];
    logic [31:0] x_mem   [MAX_ORDER];

    dstate_t          st_reg;
    dp_cmd_t          c_reg;
    logic [CNT_W-1:0] k_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic             pv_reg;
    logic [31:0]      mrd0_reg, mrd1_reg, xk_rd_reg, xr_rd_reg, xrd_reg;
    logic [31:0]      diff_reg;
    logic             rd_v_reg;
    logic             piv_reg, satf_reg;
    logic             div_start;
    logic             div_done, div_sat;
    logic [31:0]      div_quo;

    logic [ADDR_W-1:0] a_addr, b_addr, base_addr, piv_addr, rd0_addr, rd1_addr;
    logic [IDX_W-1:0]  kk;
    logic              x_dst;
    logic [31:0]       a_rd, b_rd, base_rd, piv_rd;
    logic [31:0]       base_val, diff_val;
    logic              diff_f;
    logic signed [63:0] sh_prod;

    always_comb begin
        kk        = k_reg[IDX_W-1:0];
        x_dst     = (c_reg.dst == DST_X_DIV) || (c_reg.dst == DST_X_PLAIN);
        a_addr    = {c_reg.r, kk};
        b_addr    = {kk, c_reg.c};
        base_addr = {c_reg.r, c_reg.c};
        piv_addr  = {c_reg.r, c_reg.r};
        // Two read ports: operands while the MAC runs, base entry and pivot otherwise.
        rd0_addr  = (st_reg == D_MAC) ? a_addr : base_addr;
        rd1_addr  = (st_reg == D_MAC) ? b_addr : piv_addr;
        a_rd      = mrd0_reg;
        b_rd      = x_dst ? xk_rd_reg : mrd1_reg;
        base_rd   = (c_reg.dst == DST_X_PLAIN) ? xr_rd_reg : mrd0_reg;
        piv_rd    = mrd1_reg;
        sh_prod   = prod_reg >>> FRAC_BITS;
        base_val  = (c_reg.dst == DST_X_DIV) ? vec_mem[c_reg.r] : base_rd;
        diff_val  = sat32(64'($signed(base_val)) - acc_reg, diff_f);
    end

    // Memory writes/reads (registered read data).
    always_ff @(posedge aclk) begin
        if (ld_a) mat_mem[{ld_row, ld_col}] <= ld_value;
        if (ld_b) vec_mem[ld_row] <= ld_value;
        mrd0_reg    <= mat_mem[rd0_addr];
        mrd1_reg    <= mat_mem[rd1_addr];
        xk_rd_reg   <= x_mem[kk];
        xr_rd_reg   <= x_mem[c_reg.r];
        xrd_reg     <= x_mem[xrd_idx];
        prod_reg    <= $signed(a_rd) * $signed(b_rd);
        if (st_reg == D_FIN) diff_reg <= diff_val;
        if (st_reg == D_FIN && (c_reg.dst == DST_MAT_PLAIN)) mat_mem[base_addr] <= diff_val;
        if (st_reg == D_FIN && (c_reg.dst == DST_X_PLAIN)) x_mem[c_reg.r] <= diff_val;
        if (st_reg == D_DIV && div_done) begin
            if (c_reg.dst == DST_MAT_DIV) mat_mem[base_addr] <= div_quo;
            else x_mem[c_reg.r] <= div_quo;
        end
        if (st_reg == D_DIVRD && piv_rd == '0) begin
            if (c_reg.dst == DST_MAT_DIV) mat_mem[base_addr] <= '0;
            else x_mem[c_reg.r] <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= D_IDLE;
            piv_reg  <= 1'b0;
            satf_reg <= 1'b0;
            pv_reg   <= 1'b0;
            rd_v_reg <= 1'b0;
        end else begin
            pv_reg   <= rd_v_reg;
            rd_v_reg <= 1'b0;
            if (pv_reg) acc_reg <= acc_reg + sh_prod;
            case (st_reg)
                D_IDLE: if (cmd.start) begin
                    c_reg   <= cmd;
                    k_reg   <= cmd.k_lo;
                    acc_reg <= '0;
                    if (cmd.clr_flags) begin
                        piv_reg <= 1'b0; satf_reg <= 1'b0;
                    end
                    st_reg <= D_RDA;
                end
                D_RDA: st_reg <= D_MAC;  // address settles, first reads land
                D_MAC: begin
                    if (k_reg < c_reg.k_hi) begin
                        rd_v_reg <= 1'b1;
                        k_reg    <= k_reg + CNT_W'(1);
                    end else begin
                        st_reg <= D_WAIT;
                    end
                end
                D_WAIT: if (!rd_v_reg && !pv_reg) st_reg <= D_FIN;
                D_FIN: begin
                    if (diff_f) satf_reg <= 1'b1;
                    if (c_reg.dst == DST_MAT_DIV || c_reg.dst == DST_X_DIV)
                        st_reg <= D_DIVRD;
                    else
                        st_reg <= D_DONE;
                end
                D_DIVRD: begin
                    if (piv_rd == '0) begin
                        piv_reg <= 1'b1;
                        st_reg  <= D_DONE;
                    end else begin
                        st_reg <= D_DIV;
                    end
                end
                D_DIV: if (div_done) begin
                    if (div_sat) satf_reg <= 1'b1;
                    st_reg <= D_DONE;
                end
                D_DONE: st_reg <= D_IDLE;
                default: st_reg <= D_IDLE;
            endcase
        end
    end

    assign div_start = (st_reg == D_DIVRD) && (piv_rd != '0);

    clu_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(diff_reg), .den(piv_rd),
        .done(div_done), .quo(div_quo), .sat(div_sat)
    );

    assign sts.done = (st_reg == D_DONE);
    assign xrd_data = xrd_reg;
    assign status   = piv_reg ? ST_PIVOT : (satf_reg ? ST_SAT : ST_OK);
endmodule

// ===== hdl/clu_ctrl.sv =====
// Controller: sequences Crout factor, forward and back substitution, and output.
module clu_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       solve_start,
    input  logic [clu_pkg::SIZE_W-1:0] matrix_size,
    output clu_pkg::dp_cmd_t           cmd,
    input  clu_pkg::dp_sts_t           sts,
    output logic                       busy,
    output logic [clu_pkg::IDX_W-1:0]  xrd_idx,
    output logic                       emit,
    output logic                       emit_last,
    input  logic                       emit_taken
);
    import clu_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE, C_ISSUE, C_WAIT, C_OUT_RD, C_OUT_RD2, C_OUT
    } cstate_t;

    typedef enum logic [2:0] {
        P_DIAG, P_COL, P_ROW, P_FWD, P_BWD
    } phase_t;

    cstate_t          st_reg;
    phase_t           ph_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] i_reg, j_reg;
    dp_cmd_t          cmd_reg;
    logic             first_reg;

    logic [CNT_W-1:0] n_eff;
    always_comb begin
        if (matrix_size == '0) n_eff = CNT_W'(1);
        else if (matrix_size > SIZE_W'(MAX_ORDER)) n_eff = CNT_W'(MAX_ORDER);
        else n_eff = CNT_W'(matrix_size);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= C_IDLE;
            cmd_reg.start <= 1'b0;
        end else begin
            cmd_reg.start <= 1'b0;
            case (st_reg)
                C_IDLE: if (solve_start) begin
                    n_reg     <= n_eff;
                    ph_reg    <= P_DIAG;
                    i_reg     <= '0;
                    j_reg     <= '0;
                    first_reg <= 1'b1;
                    st_reg    <= C_ISSUE;
                end
                C_ISSUE: begin
                    // Skip empty column/row phases and advance the sweep.
                    if ((ph_reg == P_COL || ph_reg == P_ROW) && j_reg >= n_reg) begin
                        if (ph_reg == P_COL) begin
                            ph_reg <= P_ROW; j_reg <= i_reg + CNT_W'(1);
                        end else if (i_reg + CNT_W'(1) >= n_reg) begin
                            ph_reg <= P_FWD; j_reg <= '0;
                        end else begin
                            ph_reg <= P_DIAG; i_reg <= i_reg + CNT_W'(1);
                        end
                    end else if (ph_reg == P_FWD && j_reg >= n_reg) begin
                        ph_reg <= P_BWD; j_reg <= n_reg - CNT_W'(1);
                    end else if (ph_reg == P_BWD && j_reg == '0) begin
                        j_reg <= '0; st_reg <= C_OUT_RD;
                    end else begin
                        cmd_reg.start     <= 1'b1;
                        cmd_reg.clr_flags <= first_reg;
                        first_reg         <= 1'b0;
                        case (ph_reg)
                            P_DIAG: begin
                                cmd_reg.dst <= DST_MAT_PLAIN;
                                cmd_reg.r <= i_reg[IDX_W-1:0]; cmd_reg.c <= i_reg[IDX_W-1:0];
                                cmd_reg.k_lo <= '0; cmd_reg.k_hi <= i_reg;
                            end
                            P_COL: begin
                                cmd_reg.dst <= DST_MAT_PLAIN;
                                cmd_reg.r <= j_reg[IDX_W-1:0]; cmd_reg.c <= i_reg[IDX_W-1:0];
                                cmd_reg.k_lo <= '0; cmd_reg.k_hi <= i_reg;
                            end
                            P_ROW: begin
                                cmd_reg.dst <= DST_MAT_DIV;
                                cmd_reg.r <= i_reg[IDX_W-1:0]; cmd_reg.c <= j_reg[IDX_W-1:0];
                                cmd_reg.k_lo <= '0; cmd_reg.k_hi <= i_reg;
                            end
                            P_FWD: begin
                                cmd_reg.dst <= DST_X_DIV;
                                cmd_reg.r <= j_reg[IDX_W-1:0]; cmd_reg.c <= j_reg[IDX_W-1:0];
                                cmd_reg.k_lo <= '0; cmd_reg.k_hi <= j_reg;
                            end
                            default: begin
                                cmd_reg.dst <= DST_X_PLAIN;
                                cmd_reg.r <= IDX_W'(j_reg - CNT_W'(1));
                                cmd_reg.c <= IDX_W'(j_reg - CNT_W'(1));
                                cmd_reg.k_lo <= j_reg; cmd_reg.k_hi <= n_reg;
                            end
                        endcase
                        st_reg <= C_WAIT;
                    end
                end
                C_WAIT: if (sts.done) begin
                    st_reg <= C_ISSUE;
                    case (ph_reg)
                        P_DIAG:  begin ph_reg <= P_COL; j_reg <= i_reg + CNT_W'(1); end
                        P_FWD:   j_reg <= j_reg + CNT_W'(1);
                        P_BWD:   j_reg <= j_reg - CNT_W'(1);
                        default: j_reg <= j_reg + CNT_W'(1);
                    endcase
                end
                C_OUT_RD:  st_reg <= C_OUT_RD2;
                C_OUT_RD2: st_reg <= C_OUT;
                C_OUT: if (emit_taken) begin
                    if (j_reg + CNT_W'(1) >= n_reg) st_reg <= C_IDLE;
                    else begin
                        j_reg <= j_reg + CNT_W'(1); st_reg <= C_OUT_RD;
                    end
                end
                default: st_reg <= C_IDLE;
            endcase
        end
    end

    assign cmd       = cmd_reg;
    assign busy      = (st_reg != C_IDLE);
    assign xrd_idx   = j_reg[IDX_W-1:0];
    assign emit      = (st_reg == C_OUT);
    assign emit_last = (j_reg + CNT_W'(1) >= n_reg);

    a_cmd_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_reg.start |-> st_reg == C_WAIT)
        else $error("command issued outside wait");
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == C_OUT |-> j_reg < n_reg)
        else $error("output index beyond order");
    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.done |-> st_reg == C_WAIT)
        else $error("datapath done while not waiting");
endmodule

// ===== hdl/crout_lu_linear_solver.sv =====
// Top level of the Crout LU linear solver: ports, config register, output stage.
// Solves A*x = b in signed Q16.16. Load words (matrix entry, right-hand entry)
// are taken one per cycle while the input is open and written straight into
// the matrix and vector memories. A solve word closes the input until every x
// word has been sent: a controller walks the Crout factorization, forward and
// back substitution as dot-product jobs on one shared multiply-accumulate unit
// (one product per cycle) plus a bit-serial divider. Each result word is then
// read from the x memory into a registered read port and waits in the output
// state until taken. All x words of one solve carry the same status: zero pivot
// beats saturation. matrix_size is written on its own channel; the user must
// write it only while the block is idle, which the block does not enforce;
// 0 acts as 1 and values above 16 act as 16.
module crout_lu_linear_solver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [3:0]  s_row,
    input  logic [3:0]  s_col,
    input  logic signed [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_index,
    output logic signed [31:0] m_solution,
    output logic        m_last,
    output logic [1:0]  m_status
);
    import clu_pkg::*;

    logic [SIZE_W-1:0] size_reg;
    dp_cmd_t           cmd;
    dp_sts_t           sts;
    logic              busy, emit, emit_last;
    logic [IDX_W-1:0]  xrd_idx;
    logic [31:0]       xrd_data;
    logic [1:0]        status;
    logic              s_acc, solve_start;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) size_reg <= SIZE_W'(MAX_ORDER);
        else if (cfg_valid) size_reg <= cfg_data;
    end

    assign s_ready     = !busy;
    assign s_acc       = s_valid && s_ready;
    assign solve_start = s_acc && (s_operation == OP_SOLVE);

    clu_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .ld_a(s_acc && s_operation == OP_LOAD_A),
        .ld_b(s_acc && s_operation == OP_LOAD_B),
        .ld_row(s_row), .ld_col(s_col), .ld_value(s_value),
        .cmd(cmd), .sts(sts),
        .xrd_idx(xrd_idx), .xrd_data(xrd_data), .status(status)
    );

    clu_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .solve_start(solve_start),
        .matrix_size(size_reg),
        .cmd(cmd), .sts(sts), .busy(busy), .xrd_idx(xrd_idx),
        .emit(emit), .emit_last(emit_last), .emit_taken(m_valid && m_ready)
    );

    // Present the word straight from the controller's output state.
    assign m_valid    = emit;
    assign m_index    = xrd_idx;
    assign m_solution = xrd_data;
    assign m_last     = emit_last;
    assign m_status   = status;

    a_no_in_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input open during output");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_index))
        else $error("output word dropped");
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid)
        else $error("word after last");
endmodule
